// ===== hdl/slip_frame_decoder_macros.svh =====
// Assertion macros for the decoder RTL.
`ifndef SLIP_FRAME_DECODER_MACROS_SVH
`define SLIP_FRAME_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
`define SFD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SFD_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFD_ASSERT(lbl, clk, rstn, prop, msg)
`define SFD_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/sfd_pkg.sv =====
`default_nettype none

package sfd_pkg;

    localparam int FRAME_DEPTH = 64;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);

    localparam int              MIN_LEN_W     = 7;
    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = MIN_LEN_W'(3);

    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    // register index decoded from paddr[2]
    localparam logic REG_MIN_LEN = 1'b0;

    // queue depths, powers of two
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic {
        CMD_WRITE,
        CMD_EMIT
    } t_cmd_kind;

    // CMD_WRITE: store data at idx; CMD_EMIT: drain idx bytes from the store
    typedef struct packed {
        t_cmd_kind         kind;
        logic [CNT_W-1:0]  idx;
        logic [7:0]        data;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_DRAIN
    } t_back_state;

endpackage

`default_nettype wire

// ===== hdl/sfd_front.sv =====
`default_nettype none

module sfd_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire logic [7:0]                     i_rx_byte,
    input  wire logic [sfd_pkg::MIN_LEN_W-1:0]  i_min_len,
    input  wire logic                           i_q_full,
    output logic                                o_full,
    output logic                                o_cmd_push,
    output sfd_pkg::t_cmd                       o_cmd
);

    logic [sfd_pkg::CNT_W-1:0] r_fill, n_fill;
    logic                      r_esc, n_esc;
    logic                      r_ovf, n_ovf;
    logic                      w_acc;
    logic                      w_store;
    logic [7:0]                w_sbyte;

    assign o_full = i_q_full;
    assign w_acc  = i_push && !i_q_full;

    always_comb begin
        n_fill     = r_fill;
        n_esc      = r_esc;
        n_ovf      = r_ovf;
        w_store    = 1'b0;
        w_sbyte    = i_rx_byte;
        o_cmd_push = 1'b0;
        o_cmd.kind = sfd_pkg::CMD_WRITE;
        o_cmd.idx  = r_fill;
        o_cmd.data = i_rx_byte;

        if (w_acc) begin
            priority if (r_esc && (i_rx_byte == sfd_pkg::SLIP_ESC_END ||
                                   i_rx_byte == sfd_pkg::SLIP_ESC_ESC)) begin
                w_store = 1'b1;
                w_sbyte = (i_rx_byte == sfd_pkg::SLIP_ESC_END) ? sfd_pkg::SLIP_END
                                                               : sfd_pkg::SLIP_ESC;
                n_esc   = 1'b0;
            end else if (i_rx_byte == sfd_pkg::SLIP_END) begin
                if (!r_ovf && r_fill != '0 &&
                    sfd_pkg::MIN_LEN_W'(r_fill) >= i_min_len) begin
                    o_cmd_push = 1'b1;
                    o_cmd.kind = sfd_pkg::CMD_EMIT;
                end
                n_fill = '0;
                n_esc  = 1'b0;
                n_ovf  = 1'b0;
            end else if (i_rx_byte == sfd_pkg::SLIP_ESC) begin
                n_esc = 1'b1;
            end else begin
                w_store = 1'b1;
            end
        end

        if (w_store) begin
            if (r_fill < sfd_pkg::CNT_W'(sfd_pkg::FRAME_DEPTH)) begin
                o_cmd_push = 1'b1;
                o_cmd.data = w_sbyte;
                n_fill     = r_fill + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_esc  <= 1'b0;
            r_ovf  <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_esc  <= n_esc;
            r_ovf  <= n_ovf;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sfd_cmd_fifo.sv =====
`default_nettype none

module sfd_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sfd_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output sfd_pkg::t_cmd      o_cmd
);

    sfd_pkg::t_cmd                  r_mem [sfd_pkg::CMDQ_DEPTH];
    logic [sfd_pkg::CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [sfd_pkg::CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [sfd_pkg::CMDQ_CNT_W-1:0] r_cnt;
    logic                           w_wr;
    logic                           w_rd;

    assign o_full  = (r_cnt == sfd_pkg::CMDQ_CNT_W'(sfd_pkg::CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + sfd_pkg::CMDQ_CNT_W'(w_wr) - sfd_pkg::CMDQ_CNT_W'(w_rd);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sfd_back.sv =====
`default_nettype none

module sfd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sfd_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_empty,
    output logic               o_cmd_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [7:0]         o_frame_byte,
    output logic               o_last_of_frame
);

    logic [7:0] r_store [sfd_pkg::FRAME_DEPTH];

    sfd_pkg::t_back_state           r_state, n_state;
    logic [sfd_pkg::CNT_W-1:0]      r_len;
    logic [sfd_pkg::CNT_W-1:0]      r_rd_idx;
    logic                           r_rd_vld;
    logic [7:0]                     r_rd_data;
    logic                           r_rd_last;

    logic [7:0]                     r_oq_byte [sfd_pkg::OUTQ_DEPTH];
    logic                           r_oq_last [sfd_pkg::OUTQ_DEPTH];
    logic [sfd_pkg::OUTQ_PTR_W-1:0] r_oq_wr;
    logic [sfd_pkg::OUTQ_PTR_W-1:0] r_oq_rd;
    logic [sfd_pkg::OUTQ_CNT_W-1:0] r_oq_cnt;

    logic                           w_we;
    logic                           w_load;
    logic                           w_issue;
    logic                           w_is_last;
    logic                           w_room;
    logic [sfd_pkg::OUTQ_CNT_W-1:0] w_pending;
    logic                           w_oq_pop;

    // reads in flight count against queue space
    assign w_pending = r_oq_cnt + sfd_pkg::OUTQ_CNT_W'(r_rd_vld);
    assign w_room    = w_pending <= sfd_pkg::OUTQ_CNT_W'(sfd_pkg::OUTQ_DEPTH - 2);
    assign w_is_last = (r_rd_idx == r_len - sfd_pkg::CNT_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfd_pkg::BK_IDLE: begin
                if (!i_cmd_empty && i_cmd.kind == sfd_pkg::CMD_EMIT) begin
                    n_state = sfd_pkg::BK_DRAIN;
                end
            end
            sfd_pkg::BK_DRAIN: begin
                if (w_room && w_is_last) begin
                    n_state = sfd_pkg::BK_IDLE;
                end
            end
            default: n_state = sfd_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        w_we      = 1'b0;
        w_load    = 1'b0;
        w_issue   = 1'b0;
        unique case (r_state)
            sfd_pkg::BK_IDLE: begin
                o_cmd_pop = !i_cmd_empty;
                w_we      = !i_cmd_empty && i_cmd.kind == sfd_pkg::CMD_WRITE;
                w_load    = !i_cmd_empty && i_cmd.kind == sfd_pkg::CMD_EMIT;
            end
            sfd_pkg::BK_DRAIN: begin
                w_issue = w_room;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[i_cmd.idx[sfd_pkg::ADDR_W-1:0]] <= i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_data <= r_store[r_rd_idx[sfd_pkg::ADDR_W-1:0]];
            r_rd_last <= w_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_len <= i_cmd.idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sfd_pkg::BK_IDLE;
            r_rd_idx <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_issue;
            if (w_load) begin
                r_rd_idx <= '0;
            end else if (w_issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    // result queue
    assign o_empty         = (r_oq_cnt == '0);
    assign o_frame_byte    = r_oq_byte[r_oq_rd];
    assign o_last_of_frame = r_oq_last[r_oq_rd];
    assign w_oq_pop        = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_oq_byte[r_oq_wr] <= r_rd_data;
            r_oq_last[r_oq_wr] <= r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_rd_vld) begin
                r_oq_wr <= r_oq_wr + 1'b1;
            end
            if (w_oq_pop) begin
                r_oq_rd <= r_oq_rd + 1'b1;
            end
            r_oq_cnt <= r_oq_cnt + sfd_pkg::OUTQ_CNT_W'(r_rd_vld)
                        - sfd_pkg::OUTQ_CNT_W'(w_oq_pop);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/slip_frame_decoder.sv =====
// SLIP receive decoder: one raw byte per cycle in, decoded frame bytes out.
// Throughput: one byte per cycle at the input while the command queue has room; the
// queue stops draining while a frame is emitted from the store at one byte per cycle
// while the result queue has room. Once its END byte is taken, a frame's first byte
// waits behind earlier queued commands, then passes the drain state, store read register and result queue.
// Reset: synchronous, active low; clears control state and sets the minimum length to 3.
`default_nettype none

`include "slip_frame_decoder_macros.svh"

module slip_frame_decoder (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [7:0]   i_rx_byte,
    input  wire logic         pop,
    output logic              empty,
    output logic [7:0]        o_frame_byte,
    output logic              o_last_of_frame,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [sfd_pkg::MIN_LEN_W-1:0] r_min_len;
    logic                          w_cfg_wr;
    logic                          w_cmd_push;
    logic                          w_cmd_full;
    logic                          w_cmd_empty;
    logic                          w_cmd_pop;
    sfd_pkg::t_cmd                 w_cmd_in;
    sfd_pkg::t_cmd                 w_cmd_out;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[2] == sfd_pkg::REG_MIN_LEN);

    always_comb begin
        prdata = '0;
        if (paddr[2] == sfd_pkg::REG_MIN_LEN) begin
            prdata = 32'(r_min_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= sfd_pkg::MIN_LEN_RESET;
        end else if (w_cfg_wr) begin
            r_min_len <= pwdata[sfd_pkg::MIN_LEN_W-1:0];
        end
    end

    sfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_rx_byte  (i_rx_byte),
        .i_min_len  (r_min_len),
        .i_q_full   (w_cmd_full),
        .o_full     (full),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_cmd_in)
    );

    sfd_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_cmd_pop),
        .o_full  (w_cmd_full),
        .o_empty (w_cmd_empty),
        .o_cmd   (w_cmd_out)
    );

    sfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd_out),
        .i_cmd_empty     (w_cmd_empty),
        .o_cmd_pop       (w_cmd_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_frame_byte    (o_frame_byte),
        .o_last_of_frame (o_last_of_frame)
    );

    `SFD_ASSERT(a_cmd_no_overrun, i_clk, i_rst_n, !(w_cmd_push && w_cmd_full), "command pushed into full queue")
    `SFD_ASSERT(a_cfg_write, i_clk, i_rst_n, w_cfg_wr |=> (r_min_len == $past(pwdata[6:0])), "min length write lost")
    `SFD_ASSERT(a_empty_after_pop, i_clk, i_rst_n, $rose(empty) |-> $past(pop), "result vanished without pop")
    `SFD_ASSERT_NORST(a_reset_state, i_clk, !i_rst_n |=> (empty && r_min_len == sfd_pkg::MIN_LEN_RESET), "bad state after reset")

endmodule

`default_nettype wire
